// ===== rtl/lgw_pkg.sv =====
// Shared widths, register indexes, fixed-point constants and sequencer states.
package lgw_pkg;

	localparam int MS_W       = 8;
	localparam int IDX_W      = 5;
	localparam int CH_W       = 8;
	localparam int COLOR_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int COUNT_W    = 9;
	localparam int PHASE_W    = 16;
	localparam int RATIO_W    = 17;
	localparam int SPEED_W    = 8;
	localparam int SLOW_W     = 9;
	localparam int MUL_A_W    = 17;
	localparam int MUL_B_W    = 18;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int MAX_OUT    = 32;

	localparam logic [CFG_IDX_W-1:0] REG_COLOR_LIGHT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MID    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_DARK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_Q6     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_FLOW = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SLOW = 3'd5;

	localparam logic [COLOR_W-1:0] COLOR_LIGHT_RST = 24'h90EE90;
	localparam logic [COLOR_W-1:0] COLOR_MID_RST   = 24'h00FF00;
	localparam logic [COLOR_W-1:0] COLOR_DARK_RST  = 24'h006400;
	localparam logic [SPEED_W-1:0] SPEED_MIN       = 8'd64;
	localparam logic [SPEED_W-1:0] SPEED_MAX       = 8'd192;
	localparam logic [SLOW_W-1:0]  SLOW_MAX        = 9'd256;
	localparam logic [SLOW_W-1:0]  SLOW_RST        = 9'd128;

	// segment bounds of the phase, Q0.16, rounded up
	localparam logic [PHASE_W-1:0] BOUND_1 = 16'd9307;
	localparam logic [PHASE_W-1:0] BOUND_2 = 16'd18678;
	localparam logic [PHASE_W-1:0] BOUND_3 = 16'd28050;
	localparam logic [PHASE_W-1:0] BOUND_4 = 16'd37422;
	localparam logic [PHASE_W-1:0] BOUND_5 = 16'd46793;

	localparam logic [RATIO_W-1:0] RATIO_ONE    = 17'd65536;
	// frame period is floor(INTERVAL_NUM / speed) ms
	localparam logic [PROD_W-1:0]  INTERVAL_NUM = 35'd1920;
	localparam logic [MUL_B_W-1:0] FWD_SCALE    = 18'd512;
	// x / 25 == (x * RECIP_25) >> RECIP_SHIFT for x below 199728
	localparam logic [MUL_B_W-1:0] RECIP_25     = 18'd167773;
	localparam int                 RECIP_SHIFT  = 22;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_CHECK  = 11'b000_0000_0010,
		S_DECIDE = 11'b000_0000_0100,
		S_PIX    = 11'b000_0000_1000,
		S_RED    = 11'b000_0001_0000,
		S_GRN    = 11'b000_0010_0000,
		S_BLU    = 11'b000_0100_0000,
		S_FIN    = 11'b000_1000_0000,
		S_STEP1  = 11'b001_0000_0000,
		S_STEP2  = 11'b010_0000_0000,
		S_STEP3  = 11'b100_0000_0000
	} state_t;

endpackage

// ===== rtl/lgw_tick_if.sv =====
// Input channel: elapsed milliseconds per timer tick.
interface lgw_tick_if import lgw_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [MS_W-1:0] elapsed_ms;

	modport source (output valid, output elapsed_ms, input ready);
	modport sink (input valid, input elapsed_ms, output ready);
endinterface

// ===== rtl/lgw_pixel_if.sv =====
// Output channel: one LED colour per transfer.
interface lgw_pixel_if import lgw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] led_index;
	logic [CH_W-1:0]  red;
	logic [CH_W-1:0]  green;
	logic [CH_W-1:0]  blue;
	logic             last_of_frame;

	modport source (output valid, output led_index, output red, output green, output blue,
		output last_of_frame, input ready);
	modport sink (input valid, input led_index, input red, input green, input blue,
		input last_of_frame, output ready);
endinterface

// ===== rtl/led_gradient_wave_generator.sv =====
// Top level: LED gradient wave generator with one shared multiplier under a sequencer.
//
//   channel  dir  payload                                  transfer when
//   tick     in   elapsed_ms                               tick.valid & tick.ready
//   pixel    out  led_index, red, green, blue, last_of_frame pixel.valid & pixel.ready
//   cfg      in   cfg_index, cfg_data                      cfg_we
//
// A tick that starts no frame passes S_CHECK and S_DECIDE and returns to idle. A tick that
// emits n LEDs (n up to 32) runs each LED through S_PIX, S_RED, S_GRN, S_BLU and S_FIN, and
// skips the check when it carries on a frame longer than 32 LEDs; a frame end adds S_STEP1 to
// S_STEP3 (wave offset update). The single multiplier is used once per channel of each LED.
// tick.ready is high only while the sequencer is idle. A full output register stalls
// the sequencer in its final LED cycle. arst_n clears all control state at once.
module led_gradient_wave_generator import lgw_pkg::*; #(
	parameter int LEDS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lgw_tick_if.sink              tick,
	lgw_pixel_if.source           pixel,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CUR_W = (LEDS > 1) ? $clog2(LEDS) : 1;
	localparam int REM_W = 7;
	localparam int QSTEP = 65536 / LEDS;
	localparam int RSTEP = 65536 % LEDS;
	localparam logic [CUR_W-1:0]   CUR_LAST = CUR_W'(LEDS - 1);
	localparam logic [PHASE_W-1:0] Q_INC    = PHASE_W'(QSTEP);
	localparam logic [REM_W-1:0]   R_INC    = REM_W'(RSTEP);
	localparam logic [REM_W-1:0]   R_WRAP   = REM_W'(LEDS);

	state_t state_q, state_d;

	logic [COLOR_W-1:0] light_q, mid_q, dark_q;
	logic [SPEED_W-1:0] speed_q;
	logic               reverse_q;
	logic [SLOW_W-1:0]  slow_q;

	logic [PHASE_W-1:0] offset_q;
	logic [COUNT_W-1:0] count_q;
	logic [CUR_W-1:0]   cursor_q;
	logic [4:0]         batch_q;
	logic [PHASE_W-1:0] base_q;
	logic [REM_W-1:0]   rem_q;

	logic [COLOR_W-1:0] c1_q, c2_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [CH_W-1:0]    red_q, grn_q;
	logic [PROD_W-1:0]  prod_q;

	logic               out_valid_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [CH_W-1:0]    out_red_q, out_grn_q, out_blu_q;
	logic               out_last_q;

	function automatic logic [CH_W-1:0] byte_of(input logic [COLOR_W-1:0] c,
			input logic [1:0] k);
		case (k)
			2'd0:    byte_of = c[23:16];
			2'd1:    byte_of = c[15:8];
			default: byte_of = c[7:0];
		endcase
	endfunction

	// |b - a| for the channel, the operand of the blend multiply
	function automatic logic [CH_W-1:0] chan_diff(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b);
		chan_diff = (b >= a) ? (b - a) : (a - b);
	endfunction

	// truncated blend from the registered product (diff * ratio)
	function automatic logic [CH_W-1:0] chan_fin(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b, input logic [PROD_W-1:0] p);
		logic [23:0] up;
		up = p[23:0] + 24'hFFFF;
		if (b >= a) chan_fin = a + p[23:16];
		else        chan_fin = a - up[23:16];
	endfunction

	// tick accept and saturating count
	logic              tick_xfer;
	logic [COUNT_W:0]  count_sum;
	assign tick.ready = (state_q == S_IDLE);
	assign tick_xfer  = tick.valid && tick.ready;
	assign count_sum  = {1'b0, count_q} + {{(COUNT_W + 1 - MS_W){1'b0}}, tick.elapsed_ms};

	// segment selection for the current LED
	logic [PHASE_W-1:0] pos;
	logic [PHASE_W-1:0] seg_start;
	logic [COLOR_W-1:0] seg_c1, seg_c2;
	logic               seg_hold;
	logic [PHASE_W-1:0] rel;
	logic [18:0]        ratio7;
	logic [RATIO_W-1:0] seg_ratio;

	always_comb begin
		pos       = base_q + offset_q;
		seg_start = '0;
		seg_c1    = mid_q;
		seg_c2    = mid_q;
		seg_hold  = 1'b0;
		if (pos < BOUND_1) begin
			seg_c1 = light_q;
			seg_c2 = mid_q;
		end else if (pos < BOUND_2) begin
			seg_hold = 1'b1;
		end else if (pos < BOUND_3) begin
			seg_c1    = mid_q;
			seg_c2    = dark_q;
			seg_start = BOUND_2;
		end else if (pos < BOUND_4) begin
			seg_c1    = dark_q;
			seg_c2    = mid_q;
			seg_start = BOUND_3;
		end else if (pos < BOUND_5) begin
			seg_hold = 1'b1;
		end else begin
			seg_c1    = mid_q;
			seg_c2    = light_q;
			seg_start = BOUND_5;
		end
		rel    = pos - seg_start;
		ratio7 = ({3'b000, rel} << 3) - {3'b000, rel};
		if (seg_hold)                       seg_ratio = '0;
		else if (ratio7 > 19'(RATIO_ONE))   seg_ratio = RATIO_ONE;
		else                                seg_ratio = ratio7[RATIO_W-1:0];
	end

	// shared multiplier operand select
	logic               mul_en;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [1:0]         issue_ch;

	always_comb begin
		mul_en   = 1'b1;
		mul_a    = '0;
		mul_b    = '0;
		issue_ch = 2'd0;
		case (state_q)
			S_CHECK: begin
				mul_a = {{(MUL_A_W - COUNT_W){1'b0}}, count_q} + MUL_A_W'(1);
				mul_b = {{(MUL_B_W - SPEED_W){1'b0}}, speed_q};
			end
			S_RED, S_GRN, S_BLU: begin
				issue_ch = (state_q == S_RED) ? 2'd0 : (state_q == S_GRN) ? 2'd1 : 2'd2;
				mul_a = {{(MUL_A_W - CH_W){1'b0}},
					chan_diff(byte_of(c1_q, issue_ch), byte_of(c2_q, issue_ch))};
				mul_b = {1'b0, ratio_q};
			end
			S_STEP1: begin
				mul_a = {{(MUL_A_W - SPEED_W){1'b0}}, speed_q};
				mul_b = reverse_q ? {{(MUL_B_W - SLOW_W){1'b0}}, slow_q} : FWD_SCALE;
			end
			S_STEP2: begin
				mul_a = reverse_q ? {prod_q[MUL_A_W-2:0], 1'b0} : prod_q[MUL_A_W-1:0];
				mul_b = RECIP_25;
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	logic [CH_W-1:0]    fin_ch;
	logic [1:0]         fin_sel;
	logic [12:0]        step;
	logic               load;
	logic               frame_last;

	always_comb begin
		fin_sel    = (state_q == S_GRN) ? 2'd0 : (state_q == S_BLU) ? 2'd1 : 2'd2;
		fin_ch     = chan_fin(byte_of(c1_q, fin_sel), byte_of(c2_q, fin_sel), prod_q);
		step       = prod_q[RECIP_SHIFT+12:RECIP_SHIFT];
		load       = (state_q == S_FIN) && (!out_valid_q || pixel.ready);
		frame_last = (cursor_q == CUR_LAST);
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (tick_xfer) state_d = (cursor_q != '0) ? S_PIX : S_CHECK;
			S_CHECK:  state_d = S_DECIDE;
			S_DECIDE: state_d = (prod_q > INTERVAL_NUM) ? S_PIX : S_IDLE;
			S_PIX:    state_d = S_RED;
			S_RED:    state_d = S_GRN;
			S_GRN:    state_d = S_BLU;
			S_BLU:    state_d = S_FIN;
			S_FIN: begin
				if (load) begin
					if (frame_last)                    state_d = S_STEP1;
					else if (batch_q == 5'(MAX_OUT - 1)) state_d = S_IDLE;
					else                               state_d = S_PIX;
				end
			end
			S_STEP1:  state_d = S_STEP2;
			S_STEP2:  state_d = S_STEP3;
			S_STEP3:  state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			offset_q <= '0;
			count_q  <= '0;
			cursor_q <= '0;
			batch_q  <= '0;
			base_q   <= '0;
			rem_q    <= '0;
		end else begin
			state_q <= state_d;
			if (tick_xfer) begin
				count_q <= count_sum[COUNT_W] ? {COUNT_W{1'b1}} : count_sum[COUNT_W-1:0];
				batch_q <= '0;
			end
			if (state_q == S_DECIDE && prod_q > INTERVAL_NUM) begin
				count_q <= '0;
				base_q  <= '0;
				rem_q   <= '0;
			end
			if (load) begin
				batch_q <= batch_q + 5'd1;
				if (frame_last) begin
					cursor_q <= '0;
				end else begin
					cursor_q <= cursor_q + CUR_W'(1);
					if (rem_q + R_INC >= R_WRAP) begin
						base_q <= base_q + Q_INC + PHASE_W'(1);
						rem_q  <= rem_q + R_INC - R_WRAP;
					end else begin
						base_q <= base_q + Q_INC;
						rem_q  <= rem_q + R_INC;
					end
				end
			end
			if (state_q == S_STEP3) begin
				if (reverse_q) offset_q <= offset_q - {3'b000, step};
				else           offset_q <= offset_q + {3'b000, step};
			end
		end
	end

	// per-LED working registers
	always_ff @(posedge clk) begin
		if (state_q == S_PIX) begin
			c1_q    <= seg_c1;
			c2_q    <= seg_c2;
			ratio_q <= seg_ratio;
		end
		if (state_q == S_GRN) red_q <= fin_ch;
		if (state_q == S_BLU) grn_q <= fin_ch;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q   <= COLOR_LIGHT_RST;
			mid_q     <= COLOR_MID_RST;
			dark_q    <= COLOR_DARK_RST;
			speed_q   <= SPEED_MIN;
			reverse_q <= 1'b0;
			slow_q    <= SLOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLOR_LIGHT:  light_q <= cfg_data;
				REG_COLOR_MID:    mid_q   <= cfg_data;
				REG_COLOR_DARK:   dark_q  <= cfg_data;
				REG_SPEED_Q6: begin
					if (cfg_data[7:0] < SPEED_MIN)      speed_q <= SPEED_MIN;
					else if (cfg_data[7:0] > SPEED_MAX) speed_q <= SPEED_MAX;
					else                                speed_q <= cfg_data[7:0];
				end
				REG_REVERSE_FLOW: reverse_q <= cfg_data[0];
				REG_REVERSE_SLOW: slow_q <= (cfg_data[8:0] > SLOW_MAX) ? SLOW_MAX : cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_idx_q  <= IDX_W'(cursor_q);
			out_red_q  <= red_q;
			out_grn_q  <= grn_q;
			out_blu_q  <= fin_ch;
			out_last_q <= frame_last;
		end
	end

	assign pixel.valid         = out_valid_q;
	assign pixel.led_index     = out_idx_q;
	assign pixel.red           = out_red_q;
	assign pixel.green         = out_grn_q;
	assign pixel.blue          = out_blu_q;
	assign pixel.last_of_frame = out_last_q;

	// checks
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> pixel.valid)
		else $error("loaded pixel not presented");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.last_of_frame) |-> (pixel.led_index == IDX_W'(LEDS - 1)))
		else $error("frame end flagged on wrong LED");

	a_offset_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_STEP3) |=> $stable(offset_q))
		else $error("wave offset moved outside the offset update");

	a_frame_end_step: assert property (@(posedge clk) disable iff (!arst_n)
		(load && frame_last) |=> (state_q == S_STEP1 && cursor_q == '0))
		else $error("frame end did not start the offset update");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the LED gradient wave generator: directed and random ticks.
module tb import lgw_pkg::*; ();

	localparam int LEDS        = 32;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int MAX_REPORTS = 10;
	localparam int MAX_IDLE    = 18;
	localparam int RANDOM_TICKS = 260;
	localparam int SETTLE_CYCLES = 24;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [IDX_W-1:0] led_index;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic             last_of_frame;
	} pixel_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lgw_tick_if  tick ();
	lgw_pixel_if pixel ();

	led_gradient_wave_generator #(.LEDS(LEDS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.pixel     (pixel),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor copy of registers and state
	logic [COLOR_W-1:0] pal_light;
	logic [COLOR_W-1:0] pal_mid;
	logic [COLOR_W-1:0] pal_dark;
	logic [SPEED_W-1:0] speed;
	logic               reverse;
	logic [SLOW_W-1:0]  slow;
	logic [PHASE_W-1:0] offset;
	logic [COUNT_W-1:0] ms_count;
	int unsigned        cursor;

	pixel_t frame_pixels_q[$];

	int          errors = 0;
	int          ticks_sent = 0;
	int          frames_seen = 0;
	int          pixels_seen = 0;
	int          cfg_writes = 0;
	int unsigned cycles = 0;
	bit          tick_gaps_on;
	bit          pixel_stalls_on;

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [CH_W-1:0] mix_channel(int unsigned a, int unsigned b,
			int unsigned ratio);
		int unsigned d;
		if (b >= a) begin
			d = ((b - a) * ratio) >> 16;
			return CH_W'(a + d);
		end
		// falling channel: round the drop up so the result is still the floor
		d = ((a - b) * ratio + 65535) >> 16;
		return CH_W'(a - d);
	endfunction

	function automatic logic [COLOR_W-1:0] mix_color(logic [COLOR_W-1:0] c1,
			logic [COLOR_W-1:0] c2, int unsigned ratio);
		if (ratio > RATIO_ONE)
			ratio = RATIO_ONE;
		return {mix_channel(c1[23:16], c2[23:16], ratio),
			mix_channel(c1[15:8], c2[15:8], ratio),
			mix_channel(c1[7:0], c2[7:0], ratio)};
	endfunction

	function automatic logic [COLOR_W-1:0] wave_color(int unsigned led);
		int unsigned pos;
		pos = (led * 65536 / LEDS + offset) & 32'hFFFF;
		if (pos < BOUND_1)
			return mix_color(pal_light, pal_mid, pos * 7);
		if (pos < BOUND_2)
			return pal_mid;
		if (pos < BOUND_3)
			return mix_color(pal_mid, pal_dark, (pos - BOUND_2) * 7);
		if (pos < BOUND_4)
			return mix_color(pal_dark, pal_mid, (pos - BOUND_3) * 7);
		if (pos < BOUND_5)
			return pal_mid;
		return mix_color(pal_mid, pal_light, (pos - BOUND_5) * 7);
	endfunction

	task automatic predict_tick(logic [MS_W-1:0] ms);
		int unsigned total;
		int unsigned interval;
		int unsigned n;
		int unsigned sp;
		int unsigned sl;
		logic [COLOR_W-1:0] c;
		pixel_t px;
		sp = speed;
		sl = slow;
		interval = 1920 / sp;
		total = ms_count + ms;
		ms_count = (total > 511) ? 9'd511 : total[COUNT_W-1:0];
		if (cursor == 0) begin
			if (ms_count < interval)
				return;
			ms_count = '0;
		end
		n = 0;
		while (n < MAX_OUT && cursor < LEDS) begin
			c = wave_color(cursor);
			px.led_index = cursor[IDX_W-1:0];
			px.red = c[23:16];
			px.green = c[15:8];
			px.blue = c[7:0];
			px.last_of_frame = (cursor + 1 == LEDS);
			frame_pixels_q.push_back(px);
			n++;
			cursor++;
		end
		if (cursor >= LEDS) begin
			cursor = 0;
			if (reverse)
				offset = offset - PHASE_W'((sp * sl * 2) / 25);
			else
				offset = offset + PHASE_W'((sp * 512) / 25);
		end
	endtask

	// called at a falling edge, returns at the next falling edge
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			REG_COLOR_LIGHT:  pal_light = val;
			REG_COLOR_MID:    pal_mid = val;
			REG_COLOR_DARK:   pal_dark = val;
			REG_SPEED_Q6:     speed = (val[7:0] < SPEED_MIN) ? SPEED_MIN :
				(val[7:0] > SPEED_MAX) ? SPEED_MAX : val[7:0];
			REG_REVERSE_FLOW: reverse = val[0];
			REG_REVERSE_SLOW: slow = (val[8:0] > SLOW_MAX) ? SLOW_MAX : val[8:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// valid is left high so back-to-back ticks see no drop of valid in between
	task automatic send_tick(logic [MS_W-1:0] ms);
		int unsigned gap;
		gap = tick_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap != 0) begin
			tick.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick.valid = 1'b1;
		tick.elapsed_ms = ms;
		do @(posedge clk); while (!tick.ready);
		predict_tick(ms);
		ticks_sent++;
		@(negedge clk);
	endtask

	// hold off the sender until every expected pixel is out and the offset update is done
	task automatic drain();
		tick.valid = 1'b0;
		while (frame_pixels_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic test_reset_defaults();
		send_tick(8'd0);
		send_tick(8'd29);
		send_tick(8'd1);
		send_tick(8'd255);
		send_tick(8'd30);
		send_tick(8'd15);
		send_tick(8'd15);
		drain();
	endtask

	task automatic test_palette_extremes();
		write_reg(REG_COLOR_LIGHT, 24'hFFFFFF);
		write_reg(REG_COLOR_MID, 24'h000000);
		write_reg(REG_COLOR_DARK, 24'hA55AA5);
		send_tick(8'd255);
		send_tick(8'd170);
		drain();
		write_reg(REG_COLOR_LIGHT, 24'h000000);
		write_reg(REG_COLOR_MID, 24'hFFFFFF);
		write_reg(REG_COLOR_DARK, 24'h5AA55A);
		send_tick(8'd85);
		send_tick(8'd255);
		drain();
	endtask

	task automatic test_speed_limits();
		write_reg(REG_SPEED_Q6, 24'h000000);
		send_tick(8'd29);
		send_tick(8'd1);
		drain();
		write_reg(REG_SPEED_Q6, 24'hFFFFFF);
		send_tick(8'd9);
		send_tick(8'd1);
		drain();
		write_reg(REG_SPEED_Q6, 24'hABCD80);
		send_tick(8'd14);
		send_tick(8'd1);
		drain();
	endtask

	task automatic test_reverse_flow();
		write_reg(REG_REVERSE_FLOW, 24'h000001);
		write_reg(REG_REVERSE_SLOW, 24'h0001FF);
		send_tick(8'd255);
		send_tick(8'd255);
		drain();
		write_reg(REG_REVERSE_SLOW, 24'hFFFE00);
		send_tick(8'd255);
		drain();
		write_reg(REG_SPEED_Q6, 24'h0000C0);
		write_reg(REG_REVERSE_SLOW, 24'h000100);
		send_tick(8'd255);
		drain();
		write_reg(REG_REVERSE_FLOW, 24'hFFFFFE);
		send_tick(8'd255);
		drain();
	endtask

	task automatic test_spare_index();
		write_reg(REG_SPARE_6, 24'hFFFFFF);
		write_reg(REG_SPARE_7, 24'h000000);
		send_tick(8'd200);
		drain();
	endtask

	task automatic test_random_traffic(int count);
		int          left;
		int          phase_len;
		int unsigned interval;
		int unsigned pick;
		logic [MS_W-1:0] ms;
		left = count;
		while (left > 0) begin
			// new settings for every phase, extremes about half of the time
			pick = $urandom_range(0, 3);
			write_reg(REG_COLOR_LIGHT, (pick == 0) ? 24'hFFFFFF : CFG_DATA_W'($urandom()));
			write_reg(REG_COLOR_MID, (pick == 0) ? 24'h000000 : CFG_DATA_W'($urandom()));
			write_reg(REG_COLOR_DARK, (pick == 1) ? 24'hFFFFFF : CFG_DATA_W'($urandom()));
			case (pick)
				0: write_reg(REG_SPEED_Q6, 24'h000040);
				1: write_reg(REG_SPEED_Q6, 24'h0000C0);
				default: write_reg(REG_SPEED_Q6, CFG_DATA_W'($urandom()));
			endcase
			write_reg(REG_REVERSE_FLOW, CFG_DATA_W'($urandom()));
			case (pick)
				0: write_reg(REG_REVERSE_SLOW, 24'h000000);
				1: write_reg(REG_REVERSE_SLOW, 24'h000100);
				default: write_reg(REG_REVERSE_SLOW, CFG_DATA_W'($urandom_range(0, 511)));
			endcase
			pick = $urandom_range(0, 3);
			tick_gaps_on = pick[0];
			pixel_stalls_on = pick[1];
			phase_len = $urandom_range(25, 45);
			if (phase_len > left)
				phase_len = left;
			interval = 1920 / int'(speed);
			repeat (phase_len) begin
				if ($urandom_range(0, 1))
					ms = MS_W'($urandom_range(0, 2 * interval));
				else
					ms = MS_W'($urandom_range(0, 255));
				if ($urandom_range(0, 19) == 0) begin
					tick.valid = 1'b0;
					while (frame_pixels_q.size() != 0) @(negedge clk);
				end
				send_tick(ms);
			end
			left -= phase_len;
			drain();
		end
	endtask

	initial begin : pixel_sink
		int unsigned stall;
		pixel.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = pixel_stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
			if (stall != 0) begin
				pixel.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			pixel.ready = 1'b1;
			do @(posedge clk); while (!pixel.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : check_pixels
		pixel_t want;
		pixel_t got;
		if (arst_n && pixel.valid && pixel.ready) begin
			got = '{pixel.led_index, pixel.red, pixel.green, pixel.blue, pixel.last_of_frame};
			pixels_seen++;
			if (got.last_of_frame === 1'b1)
				frames_seen++;
			if (frame_pixels_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected pixel led %0d rgb %02h%02h%02h last %b", $realtime,
						got.led_index, got.red, got.green, got.blue, got.last_of_frame);
			end else begin
				want = frame_pixels_q.pop_front();
				if (got.led_index !== want.led_index || got.red !== want.red ||
						got.green !== want.green || got.blue !== want.blue ||
						got.last_of_frame !== want.last_of_frame) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: pixel mismatch exp led %0d rgb %02h%02h%02h last %b, %s",
							$realtime, want.led_index, want.red, want.green, want.blue,
							want.last_of_frame,
							$sformatf("got led %0d rgb %02h%02h%02h last %b", got.led_index,
								got.red, got.green, got.blue, got.last_of_frame));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels still expected", cycles,
				frame_pixels_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		tick.valid = 1'b0;
		tick.elapsed_ms = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tick_gaps_on = 1'b1;
		pixel_stalls_on = 1'b1;
		pal_light = COLOR_LIGHT_RST;
		pal_mid = COLOR_MID_RST;
		pal_dark = COLOR_DARK_RST;
		speed = SPEED_MIN;
		reverse = 1'b0;
		slow = SLOW_RST;
		offset = '0;
		ms_count = '0;
		cursor = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_palette_extremes();
		test_speed_limits();
		test_reverse_flow();
		test_spare_index();
		test_random_traffic(RANDOM_TICKS);
		drain();

		$display("covered %0d ticks, %0d frames, %0d pixels, %0d register writes in %0d cycles",
			ticks_sent, frames_seen, pixels_seen, cfg_writes, cycles);
		$display("palette, speed and reverse scale swept to their limits; %0d mismatches",
			errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lgw_pkg.sv
rtl/lgw_tick_if.sv
rtl/lgw_pixel_if.sv
rtl/led_gradient_wave_generator.sv
dv/tb.sv
